// ===== rtl/b3c_pkg.sv =====
package b3c_pkg;

  // compression rounds and counter width
  localparam int ROUNDS = 7;
  localparam int RND_W  = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

  // store layout: four chaining value pairs, then eight message pairs
  localparam int SLOTS = 12;
  localparam logic [3:0] SLOT_LAST = 4'd11;
  localparam logic [3:0] MSG_BASE  = 4'd4;

  // last column and last diagonal mix within a round
  localparam logic [2:0] G_LAST_COL  = 3'd3;
  localparam logic [2:0] G_LAST_DIAG = 3'd7;

  localparam logic [31:0] IV [4] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A
  };

  localparam logic [3:0] MSG_PERM [16] = '{
    4'd2, 4'd6, 4'd3, 4'd10, 4'd7, 4'd0, 4'd4, 4'd13,
    4'd1, 4'd11, 4'd12, 4'd5, 4'd9, 4'd14, 4'd15, 4'd8
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MIX,
    ST_DONE
  } b3c_state_t;

  typedef struct packed {
    logic [3:0]  pair_index;
    logic [63:0] word_pair;
    logic [63:0] block_counter;
    logic [6:0]  block_length;
    logic [6:0]  domain_flags;
  } b3c_in_t;

  typedef struct packed {
    logic [63:0] out_pair_7;
    logic [63:0] out_pair_6;
    logic [63:0] out_pair_5;
    logic [63:0] out_pair_4;
    logic [63:0] out_pair_3;
    logic [63:0] out_pair_2;
    logic [63:0] out_pair_1;
    logic [63:0] out_pair_0;
  } b3c_out_t;

  // message word used at position pos of round rnd (permutation applied rnd times)
  function automatic logic [3:0] msg_slot(input logic [RND_W-1:0] rnd, input logic [3:0] pos);
    logic [3:0] idx;
    idx = pos;
    for (int r = 0; r < ROUNDS - 1; r++) begin
      if (RND_W'(r) < rnd) begin
        idx = MSG_PERM[idx];
      end
    end
    return idx;
  endfunction

endpackage

// ===== rtl/blake3_compression_core.sv =====
// channel   ports                        handshake
// input     start, busy, in_data         taken when start && !busy
// result    out_valid, out_data          one-cycle strobe, no back-pressure
//
// pairs 0..10 are stored and leave the core idle.
// pair 11 starts compression: one shared half-G unit runs 16 half steps per
// round; busy stays high through the mix and done states, and the result
// strobe follows in the next cycle.
// reset clears only the sequencer and the strobe; the pair store is not cleared.
// the receiver cannot stall; the result register frees the core at once.
module blake3_compression_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  b3c_pkg::b3c_in_t  in_data,
  output logic              out_valid,
  output b3c_pkg::b3c_out_t out_data
);

  b3c_pkg::b3c_state_t state_r, state_nxt;

  logic [63:0] pairs_r [b3c_pkg::SLOTS];
  logic [31:0] v_r [16];
  logic [31:0] v_nxt [16];

  logic [b3c_pkg::RND_W-1:0] round_r, round_nxt;
  logic [2:0]                g_r, g_nxt;
  logic                      half_r, half_nxt;

  logic              out_valid_r, out_valid_nxt;
  b3c_pkg::b3c_out_t out_data_r, out_data_nxt;

  logic accept;
  logic compress_go;
  logic last_step;

  assign accept      = start && (state_r == b3c_pkg::ST_IDLE);
  assign compress_go = accept && (in_data.pair_index == b3c_pkg::SLOT_LAST);
  assign last_step   = (round_r == b3c_pkg::RND_W'(b3c_pkg::ROUNDS - 1)) &&
                       (g_r == b3c_pkg::G_LAST_DIAG) && half_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      b3c_pkg::ST_IDLE: begin
        if (compress_go) state_nxt = b3c_pkg::ST_MIX;
      end
      b3c_pkg::ST_MIX: begin
        if (last_step) state_nxt = b3c_pkg::ST_DONE;
      end
      b3c_pkg::ST_DONE: begin
        state_nxt = b3c_pkg::ST_IDLE;
      end
      default: state_nxt = b3c_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy          = (state_r != b3c_pkg::ST_IDLE);
    out_valid_nxt = (state_r == b3c_pkg::ST_DONE);
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // message word for the current half step
  logic [3:0]  m_slot;
  logic [3:0]  m_pair_idx;
  logic [63:0] m_pair;
  logic [31:0] m_word;

  assign m_slot     = b3c_pkg::msg_slot(round_r, {g_r, half_r});
  assign m_pair_idx = b3c_pkg::MSG_BASE + {1'b0, m_slot[3:1]};
  assign m_pair     = pairs_r[m_pair_idx];
  assign m_word     = m_slot[0] ? m_pair[63:32] : m_pair[31:0];

  // shared half-G unit on column 0 of each row
  logic [31:0] a_new, c_new, dx, bx, d_new, b_new;

  always_comb begin
    a_new = v_r[0] + v_r[4] + m_word;
    dx    = v_r[12] ^ a_new;
    d_new = half_r ? {dx[7:0], dx[31:8]} : {dx[15:0], dx[31:16]};
    c_new = v_r[8] + d_new;
    bx    = v_r[4] ^ c_new;
    b_new = half_r ? {bx[6:0], bx[31:7]} : {bx[11:0], bx[31:12]};
  end

  // state words, sequencing counters and the result
  logic [31:0] tmp [16];
  logic [1:0]  amt;
  logic [31:0] w0, w1;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      v_nxt[i] = v_r[i];
      tmp[i]   = v_r[i];
    end
    round_nxt    = round_r;
    g_nxt        = g_r;
    half_nxt     = half_r;
    out_data_nxt = out_data_r;
    amt          = 2'd1;
    w0           = '0;
    w1           = '0;

    unique case (state_r)
      b3c_pkg::ST_IDLE: begin
        if (compress_go) begin
          for (int i = 0; i < 4; i++) begin
            v_nxt[2*i]     = pairs_r[i][31:0];
            v_nxt[2*i + 1] = pairs_r[i][63:32];
            v_nxt[8 + i]   = b3c_pkg::IV[i];
          end
          v_nxt[12] = in_data.block_counter[31:0];
          v_nxt[13] = in_data.block_counter[63:32];
          v_nxt[14] = {25'd0, in_data.block_length};
          v_nxt[15] = {25'd0, in_data.domain_flags};
          round_nxt = '0;
          g_nxt     = '0;
          half_nxt  = 1'b0;
        end
      end
      b3c_pkg::ST_MIX: begin
        tmp[0]  = a_new;
        tmp[4]  = b_new;
        tmp[8]  = c_new;
        tmp[12] = d_new;
        half_nxt = ~half_r;
        if (!half_r) begin
          v_nxt[0]  = a_new;
          v_nxt[4]  = b_new;
          v_nxt[8]  = c_new;
          v_nxt[12] = d_new;
        end else begin
          // rotate rows to bring the next column or diagonal to column 0
          for (int i = 0; i < 4; i++) begin
            if (g_r == b3c_pkg::G_LAST_COL) begin
              amt = 2'(1 + i);
            end else if (g_r == b3c_pkg::G_LAST_DIAG) begin
              amt = 2'(1 - i);
            end else begin
              amt = 2'd1;
            end
            for (int c = 0; c < 4; c++) begin
              v_nxt[4*i + c] = tmp[{2'(i), 2'(c) + amt}];
            end
          end
          g_nxt = g_r + 3'd1;
          if (g_r == b3c_pkg::G_LAST_DIAG) begin
            round_nxt = round_r + b3c_pkg::RND_W'(1);
          end
        end
      end
      b3c_pkg::ST_DONE: begin
        for (int k = 0; k < 8; k++) begin
          if (k < 4) begin
            w0 = v_r[2*k] ^ v_r[2*k + 8];
            w1 = v_r[2*k + 1] ^ v_r[2*k + 9];
          end else begin
            w0 = v_r[2*k] ^ pairs_r[k - 4][31:0];
            w1 = v_r[2*k + 1] ^ pairs_r[k - 4][63:32];
          end
          out_data_nxt[64*k +: 64] = {w1, w0};
        end
      end
      default: begin
        half_nxt = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= b3c_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      round_r     <= '0;
      g_r         <= '0;
      half_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      round_r     <= round_nxt;
      g_r         <= g_nxt;
      half_r      <= half_nxt;
    end
  end

  // payload registers and pair store
  always_ff @(posedge clk) begin
    for (int i = 0; i < 16; i++) begin
      v_r[i] <= v_nxt[i];
    end
    out_data_r <= out_data_nxt;
    if (accept && (in_data.pair_index <= b3c_pkg::SLOT_LAST)) begin
      pairs_r[in_data.pair_index] <= in_data.word_pair;
    end
  end

`ifndef ASSERT_OFF
  // a result strobe lasts a single cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

  // the core is free again when the result is shown
  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy)
    else $error("result shown while core still busy");

  // the final pair starts compression
  a_final_starts: assert property (@(posedge clk) disable iff (!rst_n)
    compress_go |=> busy && !out_valid_r)
    else $error("final pair did not start compression");

  // the sequencer only finishes from the last half step
  a_done_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == b3c_pkg::ST_DONE) |-> $past(last_step))
    else $error("compression finished early");
`endif

endmodule

// ===== dv/tb_blake3_compression_core.sv =====
`timescale 1ns / 1ps

module tb_blake3_compression_core;

  // own copies of the hash constants for the digest predictor
  localparam logic [31:0] CHAIN_IV [4] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A
  };
  localparam int WORD_SCHEDULE [16] = '{
    2, 6, 3, 10, 7, 0, 4, 13, 1, 11, 12, 5, 9, 14, 15, 8
  };
  localparam int TARGET_PAIRS = 900;
  localparam int DRAIN_CYCLES = 130;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  b3c_pkg::b3c_in_t  in_data;
  logic              out_valid;
  b3c_pkg::b3c_out_t out_data;

  logic [63:0]       pair_store [b3c_pkg::SLOTS];
  b3c_pkg::b3c_out_t pending_digests [$];
  int                errors;
  int                sent_pairs;
  int                burst_left;

  blake3_compression_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // run limit
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // one g function on four state words, returns {a, b, c, d}
  function automatic logic [127:0] quarter_mix(input logic [31:0] a, b, c, d, mx, my);
    a = a + b + mx;
    d = ror32(d ^ a, 16);
    c = c + d;
    b = ror32(b ^ c, 12);
    a = a + b + my;
    d = ror32(d ^ a, 8);
    c = c + d;
    b = ror32(b ^ c, 7);
    return {a, b, c, d};
  endfunction

  // full compression over the stored pairs
  function automatic b3c_pkg::b3c_out_t compress_block(input logic [63:0] counter,
                                                       input logic [6:0] blen,
                                                       input logic [6:0] flags);
    logic [31:0]  cv [8];
    logic [31:0]  msg [16];
    logic [31:0]  shuffled [16];
    logic [31:0]  v [16];
    logic [127:0] q;
    logic [511:0] digest;
    int           a, b, c, d;
    for (int i = 0; i < 4; i++) begin
      cv[2*i]     = pair_store[i][31:0];
      cv[2*i + 1] = pair_store[i][63:32];
    end
    for (int i = 0; i < 8; i++) begin
      msg[2*i]     = pair_store[4 + i][31:0];
      msg[2*i + 1] = pair_store[4 + i][63:32];
    end
    for (int i = 0; i < 8; i++) v[i] = cv[i];
    for (int i = 0; i < 4; i++) v[8 + i] = CHAIN_IV[i];
    v[12] = counter[31:0];
    v[13] = counter[63:32];
    v[14] = {25'd0, blen};
    v[15] = {25'd0, flags};
    for (int r = 0; r < b3c_pkg::ROUNDS; r++) begin
      // message permutation between rounds
      if (r != 0) begin
        for (int i = 0; i < 16; i++) shuffled[i] = msg[WORD_SCHEDULE[i]];
        msg = shuffled;
      end
      // four column mixes, then four diagonal mixes
      for (int g = 0; g < 8; g++) begin
        if (g < 4) begin
          a = g;
          b = g + 4;
          c = g + 8;
          d = g + 12;
        end else begin
          a = g - 4;
          b = 4 + ((g - 3) % 4);
          c = 8 + ((g - 2) % 4);
          d = 12 + ((g - 1) % 4);
        end
        q = quarter_mix(v[a], v[b], v[c], v[d], msg[2*g], msg[2*g + 1]);
        {v[a], v[b], v[c], v[d]} = q;
      end
    end
    for (int i = 0; i < 8; i++) begin
      v[i]     = v[i] ^ v[i + 8];
      v[i + 8] = v[i + 8] ^ cv[i];
    end
    for (int k = 0; k < 8; k++) digest[64*k +: 64] = {v[2*k + 1], v[2*k]};
    return b3c_pkg::b3c_out_t'(digest);
  endfunction

  // update the store and queue a digest on the last pair
  task automatic absorb_pair(input b3c_pkg::b3c_in_t item);
    if (item.pair_index < b3c_pkg::SLOTS) begin
      pair_store[item.pair_index] = item.word_pair;
      sent_pairs++;
      if (item.pair_index == b3c_pkg::SLOT_LAST) begin
        pending_digests.push_back(compress_block(item.block_counter, item.block_length,
                                                 item.domain_flags));
      end
    end
  endtask

  function automatic b3c_pkg::b3c_in_t pair_item(input logic [3:0] idx,
                                                 input logic [63:0] word,
                                                 input logic [63:0] counter,
                                                 input logic [6:0] blen,
                                                 input logic [6:0] flags);
    b3c_pkg::b3c_in_t item;
    item.pair_index    = idx;
    item.word_pair     = word;
    item.block_counter = counter;
    item.block_length  = blen;
    item.domain_flags  = flags;
    return item;
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic b3c_pkg::b3c_in_t random_pair(input logic [3:0] idx);
    logic [6:0] blen;
    blen = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(65, 127)) : 7'($urandom_range(0, 64));
    return pair_item(idx, rand_word(), rand_word(), blen, 7'($urandom_range(0, 127)));
  endfunction

  // drive one request, hold until taken, then idle in bursts
  task automatic send_pair(input b3c_pkg::b3c_in_t item);
    int gap;
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
    absorb_pair(item);
    if (burst_left == 0) begin
      start <= 1'b0;
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  task automatic end_burst();
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
  endtask

  task automatic send_block();
    for (int s = 0; s < b3c_pkg::SLOTS; s++) send_pair(random_pair(4'(s)));
  endtask

  // every slot written with zeros before the first compression
  task automatic test_zero_block();
    for (int s = 0; s < b3c_pkg::SLOTS; s++) send_pair(pair_item(4'(s), '0, '0, '0, '0));
  endtask

  // all-ones words and counter, length edges, flag bits at both ends
  task automatic test_field_extremes();
    send_pair(pair_item(4'd0, '1, '0, '0, '0));
    send_pair(pair_item(b3c_pkg::MSG_BASE, '1, '0, '0, '0));
    send_pair(pair_item(b3c_pkg::SLOT_LAST, '1, '1, 7'd64, 7'h7F));
    send_pair(pair_item(b3c_pkg::SLOT_LAST, '0, '0, 7'd127, 7'h00));
    send_pair(pair_item(b3c_pkg::SLOT_LAST, 64'h1, 64'h1, 7'd65, 7'h01));
    send_pair(pair_item(b3c_pkg::SLOT_LAST, {32'h0, 32'hFFFF_FFFF}, 64'h8000_0000_0000_0000,
                        7'd1, 7'h40));
  endtask

  // indexes past the store are dropped and must leave it untouched
  task automatic test_ignored_index();
    send_pair(pair_item(4'd12, '1, '1, 7'd127, 7'h7F));
    send_pair(pair_item(4'd13, 64'hA5A5_5A5A_0F0F_F0F0, '0, 7'd3, 7'h15));
    send_pair(pair_item(4'd14, '1, '1, 7'd64, 7'h2A));
    send_pair(pair_item(4'd15, '1, '1, 7'd127, 7'h7F));
    send_pair(pair_item(b3c_pkg::SLOT_LAST, 64'h0123_4567_89AB_CDEF, 64'h42, 7'd32, 7'h0B));
  endtask

  // sender holds off until every digest is back, then resumes
  task automatic test_pause_until_drained();
    send_block();
    end_burst();
    while (pending_digests.size() != 0) @(posedge clk);
    send_block();
  endtask

  // mostly whole blocks in order, plus partial rewrites and index noise
  task automatic test_random_traffic();
    int n;
    while (sent_pairs < TARGET_PAIRS) begin
      case ($urandom_range(0, 9))
        7: begin
          n = $urandom_range(1, 6);
          repeat (n) send_pair(random_pair(4'($urandom_range(0, 10))));
          send_pair(random_pair(b3c_pkg::SLOT_LAST));
        end
        8: begin
          n = $urandom_range(1, 5);
          repeat (n) send_pair(random_pair(4'($urandom_range(0, 15))));
        end
        9: send_pair(random_pair(b3c_pkg::SLOT_LAST));
        default: send_block();
      endcase
    end
  endtask

  // compare each strobed digest with the oldest one queued
  always @(posedge clk) begin : check_digest
    b3c_pkg::b3c_out_t want;
    logic [511:0]      want_bits;
    logic [511:0]      got_bits;
    if (rst_n && out_valid) begin
      if (pending_digests.size() == 0) begin
        $error("result strobe with no request pending");
        errors++;
      end else begin
        want      = pending_digests.pop_front();
        want_bits = want;
        got_bits  = out_data;
        for (int k = 0; k < 8; k++) begin
          if (got_bits[64*k +: 64] !== want_bits[64*k +: 64]) begin
            $error("out_pair_%0d expected %h actual %h", k, want_bits[64*k +: 64],
                   got_bits[64*k +: 64]);
            errors++;
          end
        end
      end
    end
  end

  // stimulus sequence
  initial begin
    errors     = 0;
    sent_pairs = 0;
    burst_left = 0;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_data    = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_zero_block();
    test_field_extremes();
    test_ignored_index();
    test_pause_until_drained();
    test_random_traffic();
    end_burst();
    while (pending_digests.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
